FILE: rtl/double_to_multilimb_fixed_assert.svh
// Assertion macros used by the converter back end.
`ifndef DOUBLE_TO_MULTILIMB_FIXED_ASSERT_SVH
`define DOUBLE_TO_MULTILIMB_FIXED_ASSERT_SVH
`ifndef SYNTH
`define DMF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dmf assertion failed");
`define DMF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("dmf assertion failed");
`else
`define DMF_ASSERT(lbl, clk, rstn, prop)
`define DMF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/dmf_pkg.sv
// Shared types, constants and layout helpers for the double to limb converter.
package dmf_pkg;

    localparam int MANT_W  = 54;
    localparam int SHAMT_W = 13;
    localparam int FRAME_W = 128;

    // Register indexes
    localparam logic REG_LIMB_KIND     = 1'b0;
    localparam logic REG_OVERFLOW_MODE = 1'b1;

    // Overflow modes
    localparam logic MODE_SATURATE = 1'b0;
    localparam logic MODE_WRAP     = 1'b1;

    // Fixed aligned shift of a rounded negative-wrap result
    localparam logic signed [SHAMT_W-1:0] NEG_WRAP_SHAMT = 13'sd75;

    // One classified conversion waiting for the back end
    typedef struct packed {
        logic               full;
        logic [MANT_W-1:0]  mant;
        logic [SHAMT_W-1:0] shamt;
        logic [1:0]         kind;
    } dmf_entry_t;

    // Limb width in bits for a layout code
    function automatic logic [6:0] kind_width(input logic [1:0] kind);
        kind_width = 7'd8 << kind;
    endfunction

    // Limb count for a layout code
    function automatic logic [2:0] kind_count(input logic [1:0] kind);
        case (kind)
            2'd0:    kind_count = 3'd6;
            2'd1:    kind_count = 3'd4;
            2'd2:    kind_count = 3'd3;
            default: kind_count = 3'd2;
        endcase
    endfunction

endpackage

FILE: rtl/dmf_front.sv
// Front end: classifies a binary64 pattern and reduces it to mantissa and shift.
module dmf_front import dmf_pkg::*; (
    input  logic [63:0] double_bits,
    input  logic [1:0]  limb_kind,
    input  logic        overflow_mode,
    output dmf_entry_t  entry
);

    logic                      sign;
    logic [10:0]               ef;
    logic [51:0]               frac;
    logic [10:0]               e_eff;
    logic [52:0]               mant;
    logic [6:0]                w;
    logic signed [SHAMT_W-1:0] e_s;
    logic signed [SHAMT_W-1:0] w_s;
    logic signed [SHAMT_W-1:0] pos_shamt;
    logic                      too_big;
    logic signed [SHAMT_W-1:0] t;
    logic [SHAMT_W-1:0]        r;
    logic [52:0]               q;
    logic                      rnd;
    logic                      stk;
    logic [52:0]               low_mask;
    logic [53:0]               a;
    logic                      up;
    logic [53:0]               d;

    assign sign  = double_bits[63];
    assign ef    = double_bits[62:52];
    assign frac  = double_bits[51:0];
    assign e_eff = (ef == 11'd0) ? 11'd1 : ef;
    assign mant  = {ef != 11'd0, frac};
    assign w     = kind_width(limb_kind);
    assign e_s   = $signed({2'b00, e_eff});
    assign w_s   = $signed({6'b0, w});

    // Shift that places the value into the left-aligned 128-bit frame
    assign pos_shamt = e_s - 13'sd947 - w_s;
    assign too_big   = (e_s - 13'sd1023) >= w_s;

    // Scale |x| so that bit 0 is 2^(W-53); keep round and sticky below
    assign t = e_s - 13'sd1022 - w_s;
    assign r = 13'(-t);

    always_comb begin
        q        = 53'd0;
        rnd      = 1'b0;
        stk      = 1'b0;
        low_mask = '0;
        if (t >= 13'sd0) begin
            if (t < 13'sd53) begin
                q = mant << t[5:0];
            end
        end else begin
            if (r < 13'd53) begin
                q = mant >> r[5:0];
            end
            if (r <= 13'd53) begin
                rnd = mant[6'(r - 13'd1)];
                low_mask = (53'd1 << 6'(r - 13'd1)) - 53'd1;
            end else begin
                low_mask = '1;
            end
            stk = |(mant & low_mask);
        end
    end

    // Round 2^53 - q - f to nearest even
    always_comb begin
        a  = 54'h20000000000000 - 54'd1 - {1'b0, q};
        up = !rnd || (!stk && a[0]);
        if (!rnd && !stk) begin
            d = 54'h20000000000000 - {1'b0, q};
        end else begin
            d = a + {53'd0, up};
        end
    end

    // Select the reduced form per class
    always_comb begin
        entry.full  = 1'b0;
        entry.mant  = '0;
        entry.shamt = pos_shamt;
        entry.kind  = limb_kind;
        if (ef == 11'h7FF) begin
            entry.full = !sign && (frac == 52'd0);
        end else if (sign) begin
            if (overflow_mode == MODE_WRAP) begin
                entry.mant  = d[53] ? '0 : d;
                entry.shamt = NEG_WRAP_SHAMT;
            end
        end else if (too_big && overflow_mode == MODE_SATURATE) begin
            entry.full = 1'b1;
        end else begin
            entry.mant = {1'b0, mant};
        end
    end

endmodule

FILE: rtl/dmf_fifo.sv
// Two-entry queue between the front and back ends.
module dmf_fifo import dmf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  dmf_entry_t push_data,
    input  logic       pop,
    output dmf_entry_t pop_data,
    output logic       full,
    output logic       empty
);

    dmf_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/dmf_back.sv
// Back end: builds the fixed-point frame and emits one limb per transaction.
`include "double_to_multilimb_fixed_assert.svh"
module dmf_back import dmf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  dmf_entry_t head,
    input  logic       head_valid,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [71:0] m_tdata,   // [63:0] limb_value, [66:64] limb_index, rest zero
    output logic       m_tlast
);

    logic                      busy_reg, busy_next;
    logic [FRAME_W-1:0]        frame_reg, frame_next;
    logic [2:0]                idx_reg, idx_next;
    logic                      full_reg, full_next;
    logic [1:0]                kind_reg, kind_next;
    logic [FRAME_W-1:0]        head_frame;
    logic signed [SHAMT_W-1:0] sa;
    logic [SHAMT_W-1:0]        ra;
    logic [6:0]                w;
    logic                      last;
    logic [63:0]               limb;

    assign w    = kind_width(kind_reg);
    assign last = idx_reg == (kind_count(kind_reg) - 3'd1);

    // Place the mantissa into the left-aligned frame
    assign sa = $signed(head.shamt);
    assign ra = 13'(-sa);
    always_comb begin
        head_frame = '0;
        if (sa >= 13'sd0) begin
            if (sa < 13'sd128) begin
                head_frame = {74'd0, head.mant} << sa[6:0];
            end
        end else if (ra < 13'd54) begin
            head_frame = {74'd0, head.mant >> ra[5:0]};
        end
    end

    // Drive the current limb
    always_comb begin
        if (full_reg) begin
            limb = {64{1'b1}} >> (7'd64 - w);
        end else begin
            limb = frame_reg[127:64] >> (7'd64 - w);
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {5'd0, idx_reg, limb};
    assign pop      = head_valid && (!busy_reg || (m_tready && last));

    // Advance the limb emitter; load the next conversion when idle or as the last limb leaves
    always_comb begin
        busy_next  = busy_reg;
        frame_next = frame_reg;
        idx_next   = idx_reg;
        full_next  = full_reg;
        kind_next  = kind_reg;
        if (pop) begin
            busy_next  = 1'b1;
            frame_next = head_frame;
            idx_next   = 3'd0;
            full_next  = head.full;
            kind_next  = head.kind;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                frame_next = frame_reg << w;
                idx_next   = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            kind_reg <= 2'd1;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        full_reg  <= full_next;
    end

    `DMF_ASSERT(a_idx_in_range, aclk, aresetn, busy_reg |-> idx_reg < kind_count(kind_reg))
    `DMF_ASSERT(a_pop_when_free, aclk, aresetn, pop |-> (!busy_reg || (m_tready && last)))
    `DMF_ASSERT(a_run_continues, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)

endmodule

FILE: rtl/double_to_multilimb_fixed.sv
// An accepted transaction is queued, then loaded into the emitter's frame register.
// Throughput: one limb per cycle while m_tready is high; each item is 6, 4, 3 or 2
// limbs, from the single limb emitter draining its frame behind a two-entry queue.
// Reset: synchronous active-low aresetn empties the queue and emitter and sets
// limb_kind to 1 (4 x 16-bit) and overflow_mode to saturate.
module double_to_multilimb_fixed import dmf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] double_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] limb_value, [66:64] limb_index, rest zero
    output logic        m_tlast,   // last_limb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] limb_kind_reg, limb_kind_next;
    logic       overflow_mode_reg, overflow_mode_next;
    logic       cfg_wr;
    dmf_entry_t front_entry;
    dmf_entry_t head;
    logic       q_full, q_empty, pop, push;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        limb_kind_next     = limb_kind_reg;
        overflow_mode_next = overflow_mode_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_LIMB_KIND:     limb_kind_next = pwdata[1:0];
                REG_OVERFLOW_MODE: overflow_mode_next = pwdata[0];
                default:           limb_kind_next = limb_kind_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LIMB_KIND: prdata = {30'd0, limb_kind_reg};
            default:       prdata = {31'd0, overflow_mode_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limb_kind_reg     <= 2'd1;
            overflow_mode_reg <= MODE_SATURATE;
        end else begin
            limb_kind_reg     <= limb_kind_next;
            overflow_mode_reg <= overflow_mode_next;
        end
    end

    // Accept while the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    dmf_front u_front (
        .double_bits   (s_tdata),
        .limb_kind     (limb_kind_reg),
        .overflow_mode (overflow_mode_reg),
        .entry         (front_entry)
    );

    dmf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_entry),
        .pop       (pop),
        .pop_data  (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    dmf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: tb/double_to_multilimb_fixed_checker.sv
// Checker for the double to limb converter: tracks config, predicts limbs, compares.
module double_to_multilimb_fixed_checker import dmf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] double_bits
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [63:0] limb_value, [66:64] limb_index
    input  logic        m_tlast,   // last_limb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          limbs_pending
);

    typedef struct {
        logic [63:0] value;
        logic [2:0]  idx;
        logic        last;
    } limb_t;

    limb_t       limb_q[$];
    logic [1:0]  kind_shadow;
    logic        mode_shadow;

    // Round a finite double toward zero
    function automatic real chop_real(input real x);
        logic [63:0] u;
        int          ex;
        u  = $realtobits(x);
        ex = int'(u[62:52]) - 1023;
        if (ex >= 52) return x;
        if (ex < 0) return $bitstoreal({u[63], 63'd0});
        u &= ~((64'd1 << (52 - ex)) - 64'd1);
        return $bitstoreal(u);
    endfunction

    // Convert one double and queue its limbs
    task automatic predict_limbs(input logic [63:0] raw);
        int          cnt;
        int          lw;
        int          sh;
        real         radix;
        real         val;
        logic        full;
        logic        neg;
        logic [10:0] ef;
        logic [51:0] frac;
        logic [63:0] mask;
        logic [63:0] vb;
        logic [63:0] mant;
        logic [63:0] win;
        limb_t       e;
        case (kind_shadow)
            2'd0:    begin cnt = 6; radix = 256.0; end
            2'd1:    begin cnt = 4; radix = 65536.0; end
            2'd2:    begin cnt = 3; radix = 4294967296.0; end
            default: begin cnt = 2; radix = 18446744073709551616.0; end
        endcase
        lw   = 8 << kind_shadow;
        mask = (lw >= 64) ? '1 : ((64'd1 << lw) - 64'd1);
        ef   = raw[62:52];
        frac = raw[51:0];
        neg  = raw[63];
        full = 1'b0;
        val  = 0.0;
        if (ef == 11'h7FF) begin
            if (frac == 0 && !neg) full = 1'b1;
        end else begin
            val = $bitstoreal(raw);
            if (val < 0.0) begin
                if (mode_shadow == MODE_WRAP) begin
                    val = val - chop_real(val / radix) * radix;
                    if (val < 0.0) val = val + radix;
                end else begin
                    val = 0.0;
                end
            end
            if (val >= radix) begin
                if (mode_shadow == MODE_WRAP) val = val - chop_real(val / radix) * radix;
                else full = 1'b1;
            end
        end
        vb = $realtobits(val);
        if (vb[62:52] == 0) begin
            mant = {12'd0, vb[51:0]};
            sh   = -1074;
        end else begin
            mant = {11'd0, 1'b1, vb[51:0]};
            sh   = int'(vb[62:52]) - 1075;
        end
        for (int n = 0; n < cnt; n++) begin
            if (sh + n * lw >= 0)
                win = (sh + n * lw >= 64) ? 64'd0 : mant << (sh + n * lw);
            else
                win = (-(sh + n * lw) >= 64) ? 64'd0 : mant >> (-(sh + n * lw));
            e.value = full ? mask : (win & mask);
            e.idx   = n[2:0];
            e.last  = (n == cnt - 1);
            limb_q.push_back(e);
        end
    endtask

    // Track registers, predict on input transactions, compare output transactions
    always @(posedge aclk) begin
        limb_t e;
        if (!aresetn) begin
            kind_shadow <= 2'd1;
            mode_shadow <= MODE_SATURATE;
            limb_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_LIMB_KIND, 2'b00}) kind_shadow <= pwdata[1:0];
                else if (paddr == {REG_OVERFLOW_MODE, 2'b00}) mode_shadow <= pwdata[0];
            end
            if (s_tvalid && s_tready) predict_limbs(s_tdata);
            if (m_tvalid && m_tready) begin
                if (limb_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected limb: value=%h idx=%0d last=%b",
                                 m_tdata[63:0], m_tdata[66:64], m_tlast);
                end else begin
                    e = limb_q.pop_front();
                    if (e.value !== m_tdata[63:0] || e.idx !== m_tdata[66:64]
                        || e.last !== m_tlast) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("limb mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     e.value, e.idx, e.last,
                                     m_tdata[63:0], m_tdata[66:64], m_tlast);
                    end
                end
            end
        end
        limbs_pending = limb_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Stimulus and verdict for the double to limb converter.
module testbench import dmf_pkg::*;;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] double_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [63:0] limb_value, [66:64] limb_index
    logic        m_tlast;   // last_limb
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          limbs_pending;
    logic        steady;

    double_to_multilimb_fixed u_top (.*);

    double_to_multilimb_fixed_checker u_chk (.*);

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side stalls
    initial begin
        int g;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g == 0) m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // Register write over setup and access cycles
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Send one double, then optionally idle; tready only moves at rising edges
    task automatic send_double(input logic [63:0] bits);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (g) @(negedge aclk);
        end
    endtask

    // Random double, mostly in the range the limbs can show
    function automatic logic [63:0] rand_double();
        logic [63:0] b;
        int          r;
        b = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r < 7) b[62:52] = 11'(1023 + $urandom_range(0, 140) - 70);
        else if (r == 7) b[62:52] = ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000;
        return b;
    endfunction

    task automatic wait_drained();
        while (limbs_pending != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    logic [63:0] edge_vals[$];

    initial begin
        logic [1:0] kinds[8];
        logic       modes[8];
        kinds = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
        modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        edge_vals = '{64'h0, 64'h8000_0000_0000_0000, $realtobits(1.0), $realtobits(0.5),
                      $realtobits(-1.5), 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                      64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                      $realtobits(255.99609375), $realtobits(256.0),
                      $realtobits(65535.5), $realtobits(65536.0),
                      $realtobits(4294967296.0), $realtobits(18446744073709549568.0),
                      $realtobits(18446744073709551616.0), $realtobits(-1.0e-30),
                      $realtobits(-256.0), $realtobits(-65536.25),
                      $realtobits(3.0e5), $realtobits(1.0 / 3.0)};
        steady   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 8; p++) begin
            // Reconfigure only while idle; first phase keeps reset values
            if (p > 0) begin
                reg_write({REG_LIMB_KIND, 2'b00}, {$urandom} & ~32'h3 | kinds[p]);
                reg_write({REG_OVERFLOW_MODE, 2'b00}, {$urandom} & ~32'h1 | modes[p]);
            end
            steady = (p == 3);
            foreach (edge_vals[i]) send_double(edge_vals[i]);
            for (int i = 0; i < 25; i++) begin
                if (i == 12 && p == 2) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_double(rand_double());
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end
        repeat (10) @(posedge aclk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // Timeout
    initial begin
        #10000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dmf_pkg.sv
rtl/dmf_front.sv
rtl/dmf_fifo.sv
rtl/dmf_back.sv
rtl/double_to_multilimb_fixed.sv
tb/double_to_multilimb_fixed_checker.sv
tb/testbench.sv
